[rtl/sbrc_pkg.sv]
`default_nettype none

package sbrc_pkg;

    typedef enum logic [2:0] {
        ACT_SNOOP   = 3'd0,
        ACT_FETCH   = 3'd1,
        ACT_REPLY   = 3'd2,
        ACT_WBREPLY = 3'd3,
        ACT_PUSH    = 3'd4,
        ACT_FULL    = 3'd5,
        ACT_DUP     = 3'd6,
        ACT_STRAY   = 3'd7
    } t_action;

    localparam logic       FUNC_REQUEST = 1'b0;
    localparam logic       FUNC_REPLY   = 1'b1;

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_RDX   = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_PUSH  = 3'd3;

    localparam logic [1:0] SNP_INVALID  = 2'd0;
    localparam logic [1:0] SNP_MODIFIED = 2'd3;

    localparam logic [4:0] CACHE_COUNT_RESET = 5'd4;
    localparam logic [4:0] CACHE_COUNT_MIN   = 5'd2;
    localparam int         TARGET_BITS       = 16;

    typedef struct packed {
        logic load;
        logic match;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_busy;
    } t_ctl_sts;

endpackage

`default_nettype wire

[rtl/sbrc_in_if.sv]
`default_nettype none

interface sbrc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] line_addr;
    logic [2:0]  mem_op;
    logic [3:0]  requester_id;
    logic [1:0]  snoop_state;

    modport source (output valid, func, line_addr, mem_op, requester_id, snoop_state,
                    input ready);
    modport sink   (input valid, func, line_addr, mem_op, requester_id, snoop_state,
                    output ready);
endinterface

`default_nettype wire

[rtl/sbrc_out_if.sv]
`default_nettype none

interface sbrc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] out_addr;
    logic [15:0] snoop_targets;
    logic [3:0]  reply_to;

    modport source (output valid, action, out_addr, snoop_targets, reply_to,
                    input ready);
    modport sink   (input valid, action, out_addr, snoop_targets, reply_to,
                    output ready);
endinterface

`default_nettype wire

[rtl/sbrc_ctrl.sv]
`default_nettype none

module sbrc_ctrl
    import sbrc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        r_state <= S_MATCH;
                        r_ready <= 1'b0;
                    end
                end
                S_MATCH: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    // hold until the output register can take the word
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready   = r_ready;
    assign o_cmd.load   = i_in_valid && r_ready;
    assign o_cmd.match  = (r_state == S_MATCH);
    assign o_cmd.commit = (r_state == S_COMMIT) && !i_sts.out_busy;

    a_load_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !r_ready && o_cmd.match)
        else $error("accepted word not followed by match step");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.match, o_cmd.commit}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

[rtl/sbrc_dpath.sv]
`default_nettype none

module sbrc_dpath
    import sbrc_pkg::*;
#(
    parameter int PENDING_ENTRIES = 8,
    parameter int MAX_CACHES      = 16,
    parameter int ADDR_BITS       = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctl_cmd    i_cmd,
    output t_ctl_sts         o_sts,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        i_func,
    input  wire logic [31:0] i_line_addr,
    input  wire logic [2:0]  i_mem_op,
    input  wire logic [3:0]  i_requester_id,
    input  wire logic [1:0]  i_snoop_state,
    sbrc_out_if.source       o_out
);

    localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int CW = $clog2(MAX_CACHES);
    localparam int IW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam logic [4:0] CC_MAX = 5'(MAX_CACHES);

    logic [4:0]    r_cache_count;

    // latched word
    logic          r_func;
    logic [AW-1:0] r_addr;
    logic [2:0]    r_op;
    logic [3:0]    r_req;
    logic [1:0]    r_snp;

    // pending table
    logic [PENDING_ENTRIES-1:0] r_valid;
    logic [AW-1:0]              r_eaddr  [PENDING_ENTRIES];
    logic [CW-1:0]              r_ecount [PENDING_ENTRIES];
    logic [1:0]                 r_eop    [PENDING_ENTRIES];
    logic [3:0]                 r_ereq   [PENDING_ENTRIES];

    logic [PENDING_ENTRIES-1:0] r_hit;
    logic [PENDING_ENTRIES-1:0] r_free;

    // output register
    logic                   r_out_valid;
    t_action                r_act;
    logic [AW-1:0]          r_out_addr;
    logic [TARGET_BITS-1:0] r_targets;
    logic [3:0]             r_to;

    logic [4:0]             w_cc;
    logic [TARGET_BITS-1:0] w_mask;
    logic [IW-1:0]          w_hit_idx;
    logic [IW-1:0]          w_free_idx;
    logic [CW-1:0]          w_cnt_dec;
    logic                   w_has_res;
    t_action                w_act;
    logic [3:0]             w_to;
    logic                   w_alloc;
    logic                   w_dec;
    logic                   w_release;

    always_comb begin
        if (r_cache_count < CACHE_COUNT_MIN) begin
            w_cc = CACHE_COUNT_MIN;
        end else if (r_cache_count > CC_MAX) begin
            w_cc = CC_MAX;
        end else begin
            w_cc = r_cache_count;
        end
    end

    always_comb begin
        for (int i = 0; i < TARGET_BITS; i++) begin
            w_mask[i] = (5'(i) < w_cc) && (4'(i) != r_req);
        end
    end

    // lowest set index wins
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                w_hit_idx = IW'(i);
            end
            if (r_free[i]) begin
                w_free_idx = IW'(i);
            end
        end
    end

    assign w_cnt_dec = CW'(r_ecount[w_hit_idx] - CW'(1));

    always_comb begin
        w_has_res = 1'b0;
        w_act     = ACT_REPLY;
        w_to      = '0;
        w_alloc   = 1'b0;
        w_dec     = 1'b0;
        w_release = 1'b0;
        if (r_func == FUNC_REQUEST) begin
            w_has_res = 1'b1;
            if (r_op == OP_PUSH) begin
                w_act = ACT_PUSH;
            end else if (r_op > OP_PUSH) begin
                w_act = ACT_REPLY;
                w_to  = r_req;
            end else if (|r_hit) begin
                w_act = ACT_DUP;
                w_to  = r_req;
            end else if (!(|r_free)) begin
                w_act = ACT_FULL;
                w_to  = r_req;
            end else begin
                w_act   = ACT_SNOOP;
                w_alloc = 1'b1;
            end
        end else if (!(|r_hit)) begin
            w_has_res = 1'b1;
            w_act     = ACT_STRAY;
        end else begin
            w_dec = 1'b1;
            if (w_cnt_dec == '0) begin
                // final reply for this entry
                w_release = 1'b1;
                w_has_res = 1'b1;
                w_to      = r_ereq[w_hit_idx];
                if (r_snp == SNP_INVALID && r_eop[w_hit_idx] != OP_WRITE[1:0]) begin
                    w_act = ACT_FETCH;
                end else if (r_snp == SNP_MODIFIED) begin
                    w_act = ACT_WBREPLY;
                end else begin
                    w_act = ACT_REPLY;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_count <= CACHE_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_cache_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_addr <= i_line_addr[AW-1:0];
            r_op   <= i_mem_op;
            r_req  <= i_requester_id;
            r_snp  <= i_snoop_state;
        end
        if (i_cmd.match) begin
            for (int i = 0; i < PENDING_ENTRIES; i++) begin
                r_hit[i]  <= r_valid[i] && (r_eaddr[i] == r_addr);
                r_free[i] <= !r_valid[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            if (w_alloc) begin
                r_valid[w_free_idx] <= 1'b1;
            end
            if (w_release) begin
                r_valid[w_hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_alloc) begin
            r_eaddr[w_free_idx]  <= r_addr;
            r_ecount[w_free_idx] <= CW'(w_cc - 5'd1);
            r_eop[w_free_idx]    <= r_op[1:0];
            r_ereq[w_free_idx]   <= r_req;
        end
        if (i_cmd.commit && w_dec) begin
            r_ecount[w_hit_idx] <= w_cnt_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && w_has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_has_res) begin
            r_act      <= w_act;
            r_out_addr <= r_addr;
            r_targets  <= w_alloc ? w_mask : '0;
            r_to       <= w_to;
        end
    end

    assign o_sts.out_busy      = r_out_valid && !o_out.ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.action        = r_act;
    assign o_out.out_addr      = 32'(r_out_addr);
    assign o_out.snoop_targets = r_targets;
    assign o_out.reply_to      = r_to;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && !o_out.ready))
        else $error("result word overwritten while held");

    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_alloc) |-> !r_valid[w_free_idx])
        else $error("allocation into a busy entry");

    a_mask_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_alloc) |-> !w_mask[r_req])
        else $error("snoop mask includes requester");

endmodule

`default_nettype wire

[rtl/snoop_bus_response_collector_top.sv]
// channel  | dir | handshake      | word
// i_in     | in  | valid / ready  | func, line_addr, mem_op, requester_id, snoop_state
// o_out    | out | valid / ready  | action, out_addr, snoop_targets, reply_to
// cfg      | in  | i_cfg_we       | i_cfg_wdata = cache_count
//
// Each word passes through accept, address match against all pending entries,
// then table update and result load. Next word is accepted the cycle after.
// The update step waits while the output register still holds an untaken word.
// Reset is synchronous, active low; it clears the entry valid bits, output valid,
// control state and sets cache_count to 4. No clearing pass.
`default_nettype none

module snoop_bus_response_collector_top
    import sbrc_pkg::*;
#(
    parameter int PENDING_ENTRIES = 8,
    parameter int MAX_CACHES      = 16,
    parameter int ADDR_BITS       = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata,
    sbrc_in_if.sink         i_in,
    sbrc_out_if.source      o_out
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    sbrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sbrc_dpath #(
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .MAX_CACHES      (MAX_CACHES),
        .ADDR_BITS       (ADDR_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_in.func),
        .i_line_addr    (i_in.line_addr),
        .i_mem_op       (i_in.mem_op),
        .i_requester_id (i_in.requester_id),
        .i_snoop_state  (i_in.snoop_state),
        .o_out          (o_out)
    );

endmodule

`default_nettype wire
